[rtl/core/crf_pkg.sv]
// shared types, command codes and crc fold functions for the running fingerprint unit
`default_nettype none

package crf_pkg;

	localparam int unsigned CRC_W  = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CMD_W  = 2;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

	// request command codes as seen on the port
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WORD  = 2'd2;

	// internal operation after classification
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_BYTE  = 2'd1,
		OP_WORD  = 2'd2,
		OP_HOLD  = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CRC_W-1:0] operand;
	} work_t;

	// single reflected shift/xor step
	function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] x);
		crc_step = (x >> 1) ^ (CRC_POLY & {CRC_W{x[0]}});
	endfunction

	// one byte folded in: eight conditional steps
	function automatic logic [CRC_W-1:0] crc_byte(
		input logic [CRC_W-1:0]  crc,
		input logic [BYTE_W-1:0] b
	);
		logic [CRC_W-1:0] x;
		x = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			x = crc_step(x);
		end
		crc_byte = x;
	endfunction

	// matrix of the 32-step fold, worked out at elaboration only
	function automatic logic [CRC_W-1:0][CRC_W-1:0] build_word_mat();
		logic [CRC_W-1:0][CRC_W-1:0] m;
		logic [CRC_W-1:0]            col;
		m = '0;
		for (int j = 0; j < CRC_W; j++) begin
			col = '0;
			col[j] = 1'b1;
			for (int k = 0; k < CRC_W; k++) begin
				col = crc_step(col);
			end
			for (int i = 0; i < CRC_W; i++) begin
				m[i][j] = col[i];
			end
		end
		build_word_mat = m;
	endfunction

	localparam logic [CRC_W-1:0][CRC_W-1:0] WORD_MAT = build_word_mat();

	// whole word folded lsb byte first: each result bit is one xor tree
	function automatic logic [CRC_W-1:0] crc_word(
		input logic [CRC_W-1:0] crc,
		input logic [CRC_W-1:0] w
	);
		logic [CRC_W-1:0] x;
		logic [CRC_W-1:0] r;
		x = crc ^ w;
		for (int i = 0; i < CRC_W; i++) begin
			r[i] = ^(WORD_MAT[i] & x);
		end
		crc_word = r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/crf_front.sv]
// front end: classifies an incoming request into an operation and operand
`default_nettype none

module crf_front import crf_pkg::*; (
	input  wire logic [CMD_W-1:0] command,
	input  wire logic [CRC_W-1:0] data_word,
	output work_t                 work
);

	always_comb begin
		work.operand = data_word;
		unique case (command)
			CMD_CLEAR: begin
				work.op      = OP_CLEAR;
				work.operand = '0;
			end
			CMD_BYTE: begin
				work.op      = OP_BYTE;
				// upper bits play no part in a byte fold
				work.operand = {{(CRC_W-BYTE_W){1'b0}}, data_word[BYTE_W-1:0]};
			end
			CMD_WORD: begin
				work.op = OP_WORD;
			end
			default: begin
				work.op      = OP_HOLD;
				work.operand = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/crf_queue.sv]
// two-entry queue between the front end and the crc engine
`default_nettype none

module crf_queue import crf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  work_t      push_work,
	output logic       full,
	input  wire logic  pop,
	output logic       head_valid,
	output work_t      head_work
);

	localparam int unsigned DEPTH = 2;

	work_t      mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'(DEPTH));
	assign head_valid = (count_q != 2'd0);
	assign head_work  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_work;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/crf_back.sv]
// back end: running crc register and the result register
`default_nettype none

module crf_back import crf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  work_t                 head_work,
	output logic                  pop,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output logic [CRC_W-1:0]      crc_value
);

	logic [CRC_W-1:0] crc_q;
	logic             res_valid_q;
	logic [CRC_W-1:0] crc_next;

	// a new item may enter once the result slot is free or being taken
	assign pop = head_valid && (!res_valid_q || !res_stall);

	always_comb begin
		unique case (head_work.op)
			OP_CLEAR: crc_next = '0;
			OP_BYTE:  crc_next = crc_byte(crc_q, head_work.operand[BYTE_W-1:0]);
			OP_WORD:  crc_next = crc_word(crc_q, head_work.operand);
			default:  crc_next = crc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				crc_q       <= crc_next;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// the running value only moves on a pop, so it doubles as the result
	assign res_valid = res_valid_q;
	assign crc_value = crc_q;

endmodule

`default_nettype wire

[rtl/core/crc32_running_fingerprint_unit.sv]
// top level of the crc-32 running fingerprint unit
`default_nettype none

// Running CRC-32 fingerprint (reflected polynomial EDB88320, zero start value,
// no final inversion). Each request carries a command: clear sets the value to
// zero, byte folds in data_word[7:0], word folds in all of data_word as four
// bytes, least significant first, so that one fingerprint can be folded into
// another; command code 3 leaves the value as it is. Every request gives
// exactly one result, the value after that request, in order. A request is
// taken on a clock edge with req_valid high and req_stall low; its result is
// registered after it passes the queue, and a new request can be taken every
// cycle, one per clock sustained, as long as results are taken. The figure
// is set by the crc register loop, whose next value is combinational: a byte
// fold is eight shift/xor steps and a word fold is a single xor tree per bit
// built from a constant matrix. A two-entry queue sits between the front end
// and the crc engine, so req_stall rises only when the queue is full; under a
// steady stream of requests that happens in the cycle after a result is first
// held back, since one request already waits in the queue.

module crc32_running_fingerprint_unit import crf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request channel
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire logic [CMD_W-1:0] command,
	input  wire logic [CRC_W-1:0] data_word,
	// result channel
	output logic                  res_valid,
	input  wire logic             res_stall,
	output logic [CRC_W-1:0]      crc_value
);

	work_t front_work;   // classified request
	work_t head_work;    // oldest queued request
	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_head_valid;

	// front end: decode the command, mask the operand
	crf_front u_front (
		.command   (command),
		.data_word (data_word),
		.work      (front_work)
	);

	// stall comes straight from the queue's fill state, never from req_valid
	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

	crf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_work  (front_work),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_work  (head_work)
	);

	// back end: applies the operation and holds the result until taken
	crf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_work  (head_work),
		.pop        (q_pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.crc_value  (crc_value)
	);

endmodule

`default_nettype wire

[rtl/core/crf_checker.sv]
// port-level checks for the running fingerprint unit, with its bind
`default_nettype none

module crf_checker import crf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic             req_stall,
	input  wire logic [CMD_W-1:0] command,
	input  wire logic             res_valid,
	input  wire logic             res_stall,
	input  wire logic [CRC_W-1:0] crc_value
);

	logic       req_acc;
	logic       res_acc;
	logic [2:0] pend_q;   // requests taken but not yet answered

	assign req_acc = req_valid && !req_stall;
	assign res_acc = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + {2'b00, req_acc} - {2'b00, res_acc};
		end
	end

	// a held result keeps its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(crc_value))
		else $error("result changed while stalled");

	// no result without an open request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 3'd0)
		else $error("result without an open request");

	// queue plus result slot bound the open requests
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("too many open requests");

	// an empty unit never holds off requests
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd0 |-> !req_stall)
		else $error("stall raised while idle");

	// a clear taken by an idle unit passes the queue and then reads zero
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd0 && req_acc && command == CMD_CLEAR
		|-> ##2 res_valid && crc_value == '0)
		else $error("clear did not give zero");

endmodule

bind crc32_running_fingerprint_unit crf_checker u_crf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.command   (command),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.crc_value (crc_value)
);

`default_nettype wire

[bench/testbench.sv]
// self-checking bench for the running crc-32 fingerprint unit with random handshake timing
`timescale 1ns / 1ps

module testbench;
	import crf_pkg::*;

	// command code 3 has no meaning: the fingerprint must stay as it is
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	localparam int unsigned MAX_GAP        = 15;
	localparam int unsigned HOLD_CYCLES    = 100;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned MAX_REPORTS    = 10;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	logic [CMD_W-1:0] command   = CMD_CLEAR;
	logic [CRC_W-1:0] data_word = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	logic [CRC_W-1:0] crc_value;

	// bench-side copy of the running fingerprint and the values still owed
	logic [CRC_W-1:0] fingerprint_model = '0;
	logic [CRC_W-1:0] fingerprints_owed[$];
	logic [CRC_W-1:0] owed_value;

	int unsigned mismatch_count = 0;
	int unsigned idle_cycles    = 0;

	// idling switches for each side and the request for a long hold-off
	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;
	bit hold_results = 1'b0;

	crc32_running_fingerprint_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.command   (command),
		.data_word (data_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.crc_value (crc_value)
	);

	always #1 clk = ~clk;

	// reflected crc-32, one bit per iteration, lsb first
	function automatic logic [CRC_W-1:0] fold_byte_into(
		input logic [CRC_W-1:0]  crc,
		input logic [BYTE_W-1:0] octet
	);
		logic [CRC_W-1:0] acc;
		acc = crc;
		acc[BYTE_W-1:0] = acc[BYTE_W-1:0] ^ octet;
		for (int k = 0; k < BYTE_W; k++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
		end
		return acc;
	endfunction

	// fingerprint after one request has been applied
	function automatic logic [CRC_W-1:0] next_fingerprint(
		input logic [CRC_W-1:0] crc,
		input logic [CMD_W-1:0] cmd,
		input logic [CRC_W-1:0] data
	);
		logic [CRC_W-1:0] acc;
		acc = crc;
		case (cmd)
			CMD_CLEAR: begin
				acc = '0;
			end
			CMD_BYTE: begin
				acc = fold_byte_into(acc, data[7:0]);
			end
			CMD_WORD: begin
				// four bytes, least significant first
				for (int b = 0; b < CRC_W / BYTE_W; b++) begin
					acc = fold_byte_into(acc, data[b*BYTE_W +: BYTE_W]);
				end
			end
			default: begin
				acc = crc;
			end
		endcase
		return acc;
	endfunction

	// operands biased towards corner patterns
	function automatic logic [CRC_W-1:0] draw_operand();
		logic [CRC_W-1:0] one_hot;
		one_hot = '0;
		one_hot[$urandom_range(0, CRC_W-1)] = 1'b1;
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return one_hot;
			3:       return ~one_hot;
			default: return $urandom;
		endcase
	endfunction

	// offer one request, wait for it to be taken, then record the value it must give
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CRC_W-1:0] data);
		int unsigned gap;
		gap = send_idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		command   <= cmd;
		data_word <= data;
		do @(posedge clk); while (!(req_valid && !req_stall));
		fingerprint_model = next_fingerprint(fingerprint_model, cmd, data);
		fingerprints_owed.push_back(fingerprint_model);
	endtask

	task automatic note_mismatch(input string what, input logic [CRC_W-1:0] want,
		input logic [CRC_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t: %s: expected crc_value %08h, got %08h", $realtime, what, want, got);
		end
	endtask

	// edge values, every command and the ignored-operand cases
	task automatic run_directed_cases();
		send_request(CMD_CLEAR, 32'hFFFF_FFFF);   // clear ignores its operand
		send_request(CMD_BYTE,  32'h0000_0000);
		send_request(CMD_BYTE,  32'h0000_00FF);
		send_request(CMD_BYTE,  32'hFFFF_FF00);   // upper bits of a byte request ignored
		send_request(CMD_BYTE,  32'hA5A5_A55A);
		send_request(CMD_WORD,  32'h0000_0000);
		send_request(CMD_WORD,  32'hFFFF_FFFF);
		send_request(CMD_WORD,  32'h8000_0001);
		send_request(CMD_SPARE, 32'hFFFF_FFFF);   // spare code holds the value
		send_request(CMD_SPARE, 32'h0000_0000);
		send_request(CMD_CLEAR, 32'h0000_0000);
		send_request(CMD_SPARE, 32'h1234_5678);   // hold straight after clear stays zero
		send_request(CMD_WORD,  fingerprint_model);
		send_request(CMD_BYTE,  32'h0000_0001);
		send_request(CMD_BYTE,  32'h0000_0080);
		send_request(CMD_WORD,  fingerprint_model); // fold a fingerprint into itself
		send_request(CMD_CLEAR, 32'hDEAD_BEEF);
		send_request(CMD_WORD,  32'h0000_0001);
		send_request(CMD_WORD,  32'h1234_5678);
		send_request(CMD_BYTE,  32'h7FFF_FF7F);
	endtask

	// results held back for a long stretch while requests keep coming back to back
	task automatic run_backpressure_burst();
		send_idle_on = 1'b0;
		hold_results = 1'b1;
		repeat (24) begin
			send_request(($urandom_range(0, 1) != 0) ? CMD_WORD : CMD_BYTE, $urandom);
		end
		send_idle_on = 1'b1;
	endtask

	// mostly folds with random content, some clears and spare codes
	task automatic run_random_traffic(input int unsigned count, input bit send_idle,
		input bit recv_idle);
		int unsigned pick;
		logic [CMD_W-1:0] cmd;
		logic [CRC_W-1:0] data;
		send_idle_on = send_idle;
		recv_idle_on = recv_idle;
		repeat (count) begin
			pick = $urandom_range(0, 19);
			data = draw_operand();
			if (pick < 2) begin
				cmd = CMD_CLEAR;
			end else if (pick < 4) begin
				cmd = CMD_SPARE;
			end else if (pick < 11) begin
				cmd = CMD_BYTE;
			end else begin
				cmd = CMD_WORD;
				// now and then fold the current fingerprint back in
				if (pick == 19) begin
					data = fingerprint_model;
				end
			end
			send_request(cmd, data);
		end
	endtask

	// result side: random hold-off before each result, or one long hold when asked
	initial begin
		int unsigned gap;
		forever begin
			if (hold_results) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end else begin
				gap = recv_idle_on ? $urandom_range(0, MAX_GAP) : 0;
				if (gap != 0) begin
					res_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!(res_valid && !res_stall) && !hold_results);
		end
	end

	// every result taken is matched against the oldest value still owed
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (fingerprints_owed.size() == 0) begin
				note_mismatch("result with no request outstanding", '0, crc_value);
			end else begin
				owed_value = fingerprints_owed.pop_front();
				if (crc_value !== owed_value) begin
					note_mismatch("crc_value mismatch", owed_value, crc_value);
				end
			end
		end
	end

	// watchdog: too long with nothing moving on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed_cases();
		run_backpressure_burst();
		run_random_traffic(240, 1'b1, 1'b1);
		run_random_traffic(150, 1'b0, 1'b0);
		run_random_traffic(150, 1'b1, 1'b0);
		run_random_traffic(150, 1'b0, 1'b1);
		req_valid <= 1'b0;

		// drain, then a few quiet cycles to catch any stray result
		while (fingerprints_owed.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0 && fingerprints_owed.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/crf_pkg.sv
rtl/core/crf_front.sv
rtl/core/crf_queue.sv
rtl/core/crf_back.sv
rtl/core/crc32_running_fingerprint_unit.sv
rtl/core/crf_checker.sv
bench/testbench.sv
